FILE: sv/mlmt_pkg.sv
// ----------------------------------------------------------------------------
// mlmt_pkg
// types and constants shared by the modem link mode tracker
// ----------------------------------------------------------------------------
package mlmt_pkg;

  localparam int LEN_W = 6;
  localparam int RING_LEN = 4;
  localparam int CARR_LEN = 8;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_item_t;

  typedef struct packed {
    logic             link_mode;
    logic             line_complete;
    logic [LEN_W-1:0] line_length;
    logic             ring_detected;
    logic             data_valid;
    logic [7:0]       data_out;
    logic             error_seen;
    logic             carrier_lost;
  } out_item_t;

  typedef enum logic {
    MODE_CMD  = 1'b0,
    MODE_DATA = 1'b1
  } mode_t;

  typedef enum logic {
    REG_RING_ACCEPT_EN = 1'b0
  } reg_idx_t;

  localparam logic [7:0] CHAR_NL = 8'h0A;

  localparam logic [7:0] RING_PAT [RING_LEN] = '{8'h52, 8'h49, 8'h4E, 8'h47};
  localparam logic [7:0] CARR_PAT [CARR_LEN] =
    '{8'h4E, 8'h4F, 8'h20, 8'h43, 8'h41, 8'h52, 8'h52, 8'h49};

endpackage

FILE: sv/mlmt_engine.sv
// ----------------------------------------------------------------------------
// mlmt_engine
// link state registers and the per-item update of line, ring and carrier
// matchers
// ----------------------------------------------------------------------------
module mlmt_engine #(
  parameter int LINE_MAX = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                ring_accept_enable,
  input  mlmt_pkg::in_item_t  item,
  output mlmt_pkg::out_item_t result
);

  localparam int CW = $clog2(LINE_MAX + 1);

  mlmt_pkg::mode_t mode, mode_next;
  logic [CW-1:0]   line_count, line_count_next;
  logic [1:0]      ring_pos, ring_pos_next;
  logic            ring_seen, ring_seen_next;
  logic [2:0]      carr_pos, carr_pos_next;

  logic [CW-1:0]         cnt_inc;
  logic [CW+mlmt_pkg::LEN_W-1:0] len_wide;

  always_comb begin
    mode_next       = mode;
    line_count_next = line_count;
    ring_pos_next   = ring_pos;
    ring_seen_next  = ring_seen;
    carr_pos_next   = carr_pos;
    result          = '0;

    cnt_inc  = (line_count < CW'(LINE_MAX)) ? line_count + CW'(1) : line_count;
    len_wide = {{mlmt_pkg::LEN_W{1'b0}}, cnt_inc};

    if (mode == mlmt_pkg::MODE_CMD) begin
      result.line_length = len_wide[mlmt_pkg::LEN_W-1:0];
      line_count_next    = cnt_inc;
      if (item.rx_byte == mlmt_pkg::CHAR_NL) begin
        result.line_complete = 1'b1;
        result.ring_detected = ring_seen;
        if (ring_seen && ring_accept_enable) begin
          mode_next     = mlmt_pkg::MODE_DATA;
          carr_pos_next = '0;
        end
        line_count_next = '0;
        ring_pos_next   = '0;
        ring_seen_next  = 1'b0;
      end else if (item.rx_byte == mlmt_pkg::RING_PAT[ring_pos]) begin
        if (ring_pos == 2'(mlmt_pkg::RING_LEN - 1)) begin
          ring_seen_next = 1'b1;
          ring_pos_next  = '0;
        end else begin
          ring_pos_next = ring_pos + 2'd1;
        end
      end else begin
        ring_pos_next = (item.rx_byte == mlmt_pkg::RING_PAT[0]) ? 2'd1 : 2'd0;
      end
    end else begin
      if (item.rx_error) begin
        result.error_seen = 1'b1;
      end else begin
        result.data_valid = 1'b1;
        result.data_out   = item.rx_byte;
        if (item.rx_byte == mlmt_pkg::CARR_PAT[carr_pos]) begin
          if (carr_pos == 3'(mlmt_pkg::CARR_LEN - 1)) begin
            result.carrier_lost = 1'b1;
            carr_pos_next       = '0;
            mode_next           = mlmt_pkg::MODE_CMD;
            line_count_next     = '0;
            ring_pos_next       = '0;
            ring_seen_next      = 1'b0;
          end else begin
            carr_pos_next = carr_pos + 3'd1;
          end
        end else begin
          carr_pos_next = (item.rx_byte == mlmt_pkg::CARR_PAT[0]) ? 3'd1 : 3'd0;
        end
      end
    end

    result.link_mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= mlmt_pkg::MODE_CMD;
      line_count <= '0;
      ring_pos   <= '0;
      ring_seen  <= 1'b0;
      carr_pos   <= '0;
    end else if (step) begin
      mode       <= mode_next;
      line_count <= line_count_next;
      ring_pos   <= ring_pos_next;
      ring_seen  <= ring_seen_next;
      carr_pos   <= carr_pos_next;
    end
  end

endmodule

FILE: sv/modem_link_mode_tracker.sv
// ----------------------------------------------------------------------------
// modem_link_mode_tracker
// follows received radio module bytes through command and data mode
// ----------------------------------------------------------------------------
// an accepted item goes to the input register, then its result to the result
// register; throughput: one item per cycle while the result is not stalled,
// set by the state update between the input register and the result register
// synchronous reset clears mode, line state, matchers, enable and valids
// ----------------------------------------------------------------------------
module modem_link_mode_tracker #(
  parameter int LINE_MAX = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mlmt_pkg::in_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output mlmt_pkg::out_item_t res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                stage_valid;
  mlmt_pkg::in_item_t  stage_item;
  logic                advance;
  logic                ring_accept_enable;
  mlmt_pkg::out_item_t step_result;
  logic                reg_hit;

  assign advance    = stage_valid && (!res_valid || res_ready);
  assign item_ready = !stage_valid || advance;
  assign pready     = 1'b1;
  assign reg_hit    = (paddr[2] == mlmt_pkg::REG_RING_ACCEPT_EN);

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {31'b0, ring_accept_enable};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_accept_enable <= 1'b0;
    end else if (psel && penable && pwrite && reg_hit) begin
      ring_accept_enable <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  mlmt_engine #(
    .LINE_MAX(LINE_MAX)
  ) u_engine (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .ring_accept_enable (ring_accept_enable),
    .item               (stage_item),
    .result             (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

endmodule

FILE: sv/mlmt_checker.sv
// ----------------------------------------------------------------------------
// mlmt_checker
// port-level checks for the modem link mode tracker
// ----------------------------------------------------------------------------
module mlmt_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_ready,
  input logic                res_valid,
  input logic                res_ready,
  input mlmt_pkg::out_item_t res,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> res_valid && !res_ready)
    else $error("input stalled without output stall");

  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2] |=> prdata[0] == $past(pwdata[0]))
    else $error("enable register readback mismatch");

  a_lost_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.carrier_lost |-> !res.link_mode && res.data_valid)
    else $error("carrier loss without return to command mode");

endmodule

bind modem_link_mode_tracker mlmt_checker u_mlmt_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

FILE: dv/mode_tracker_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mode_tracker_check
// predicts and checks every result of the modem link mode tracker
// ----------------------------------------------------------------------------
// watches the item, result and register ports, keeps its own copy of the
// line, matcher and mode state, and compares each result field by field with
// the oldest prediction; reports mismatches and the number still outstanding
// ----------------------------------------------------------------------------
module mode_tracker_check #(
  parameter int LINE_MAX = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  mlmt_pkg::in_item_t  item,
  input  logic                res_valid,
  input  logic                res_ready,
  input  mlmt_pkg::out_item_t res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  outstanding,
  output int                  mismatches
);

  localparam logic [2:0] ADDR_RING_EN = {mlmt_pkg::REG_RING_ACCEPT_EN, 2'b00};

  mlmt_pkg::mode_t     cur_mode;
  int                  line_cnt;
  int                  ring_pos;
  logic                ring_seen;
  int                  carr_pos;
  logic                accept_en;
  mlmt_pkg::out_item_t mode_reports_q[$];

  function automatic void clear_line();
    line_cnt  = 0;
    ring_pos  = 0;
    ring_seen = 1'b0;
  endfunction

  function automatic mlmt_pkg::out_item_t track_rx_byte(mlmt_pkg::in_item_t it);
    mlmt_pkg::out_item_t r;
    r = '0;
    if (cur_mode == mlmt_pkg::MODE_CMD) begin
      // errors are ignored in command mode
      if (line_cnt < LINE_MAX) line_cnt++;
      r.line_length = line_cnt[mlmt_pkg::LEN_W-1:0];
      if (it.rx_byte == mlmt_pkg::CHAR_NL) begin
        r.line_complete = 1'b1;
        r.ring_detected = ring_seen;
        if (ring_seen && accept_en) begin
          cur_mode = mlmt_pkg::MODE_DATA;
          carr_pos = 0;
        end
        clear_line();
      end else if (it.rx_byte == mlmt_pkg::RING_PAT[ring_pos]) begin
        ring_pos++;
        if (ring_pos == mlmt_pkg::RING_LEN) begin
          ring_seen = 1'b1;
          ring_pos  = 0;
        end
      end else begin
        ring_pos = (it.rx_byte == mlmt_pkg::RING_PAT[0]) ? 1 : 0;
      end
    end else if (it.rx_error) begin
      // dropped, carrier matcher keeps its position
      r.error_seen = 1'b1;
    end else begin
      r.data_valid = 1'b1;
      r.data_out   = it.rx_byte;
      if (it.rx_byte == mlmt_pkg::CARR_PAT[carr_pos]) begin
        carr_pos++;
        if (carr_pos == mlmt_pkg::CARR_LEN) begin
          r.carrier_lost = 1'b1;
          carr_pos = 0;
          cur_mode = mlmt_pkg::MODE_CMD;
          clear_line();
        end
      end else begin
        carr_pos = (it.rx_byte == mlmt_pkg::CARR_PAT[0]) ? 1 : 0;
      end
    end
    r.link_mode = cur_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    mlmt_pkg::out_item_t want;
    if (rst) begin
      cur_mode  = mlmt_pkg::MODE_CMD;
      carr_pos  = 0;
      accept_en = 1'b0;
      clear_line();
      mode_reports_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_RING_EN)
        accept_en = pwdata[0];
      if (item_valid && item_ready)
        mode_reports_q.push_back(track_rx_byte(item));
      if (res_valid && res_ready) begin
        if (mode_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, res);
          mismatches++;
        end else begin
          want = mode_reports_q.pop_front();
          check_field("link_mode", 8'(want.link_mode), 8'(res.link_mode));
          check_field("line_complete", 8'(want.line_complete),
                      8'(res.line_complete));
          check_field("line_length", 8'(want.line_length), 8'(res.line_length));
          check_field("ring_detected", 8'(want.ring_detected),
                      8'(res.ring_detected));
          check_field("data_valid", 8'(want.data_valid), 8'(res.data_valid));
          check_field("data_out", want.data_out, res.data_out);
          check_field("error_seen", 8'(want.error_seen), 8'(res.error_seen));
          check_field("carrier_lost", 8'(want.carrier_lost),
                      8'(res.carrier_lost));
        end
      end
    end
    outstanding = mode_reports_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the modem link mode tracker
// ----------------------------------------------------------------------------
// sends a short directed byte stream covering ring lines, matcher retests,
// dropped bytes and carrier loss, then random lines, carrier patterns and
// noise under three sender/receiver stall mixes and both enable settings;
// a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb;

  localparam int         LINE_MAX     = 32;
  localparam int         STALL_LIMIT  = 2000;
  localparam logic [2:0] ADDR_RING_EN = {mlmt_pkg::REG_RING_ACCEPT_EN, 2'b00};
  localparam logic [2:0] ADDR_UNUSED  = 3'd4;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  mlmt_pkg::in_item_t  item;
  logic                res_valid;
  logic                res_ready;
  mlmt_pkg::out_item_t res;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int outstanding;
  int mismatches;
  int send_idle;
  int recv_idle;
  int bytes_sent;
  int quiet_cycles;

  modem_link_mode_tracker #(.LINE_MAX(LINE_MAX)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mode_tracker_check #(.LINE_MAX(LINE_MAX)) u_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (res_valid && res_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic e);
    logic took;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{rx_byte: b, rx_error: e};
    do begin
      @(negedge clk);
      took = item_ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return mlmt_pkg::RING_PAT[$urandom_range(mlmt_pkg::RING_LEN - 1)];
    if (pick < 40) return mlmt_pkg::CARR_PAT[$urandom_range(mlmt_pkg::CARR_LEN - 1)];
    if (pick < 43) return mlmt_pkg::CHAR_NL;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic err_bit(input int pct);
    return ($urandom_range(99) < pct);
  endfunction

  // one random line, carrier pattern or burst of noise
  task automatic send_chunk();
    int         kind;
    int         n;
    int         ring_at;
    logic [7:0] b;
    kind = $urandom_range(9);
    if (kind < 4) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 10);
      ring_at = ($urandom_range(1) == 0) ? $urandom_range(n) : -1;
      for (int i = 0; i <= n; i++) begin
        if (i == ring_at) begin
          for (int k = 0; k < mlmt_pkg::RING_LEN; k++) begin
            b = ($urandom_range(19) == 0) ? text_byte() : mlmt_pkg::RING_PAT[k];
            send_item(b, err_bit(10));
          end
        end
        if (i < n) send_item(text_byte(), err_bit(10));
      end
      if ($urandom_range(9) != 0) send_item(mlmt_pkg::CHAR_NL, err_bit(10));
    end else if (kind < 7) begin
      for (int k = 0; k < mlmt_pkg::CARR_LEN; k++) begin
        if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b1);
        if ($urandom_range(19) == 0) send_item(mlmt_pkg::CARR_PAT[0], 1'b0);
        b = ($urandom_range(14) == 0) ? text_byte() : mlmt_pkg::CARR_PAT[k];
        send_item(b, 1'b0);
      end
    end else begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) send_item(8'($urandom_range(255)), err_bit(20));
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    res_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    send_idle  = 25;
    recv_idle  = 60;
    bytes_sent = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unknown register is ignored, ring line with accepting disabled
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_text("RING\n");
    wait_drained();
    reg_write(ADDR_RING_EN, 32'd1);
    // broken ring retested as first R, command mode ignores errors
    send_text("RIR");
    send_item("I", 1'b1);
    send_text("NG\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("NNO");
    send_item("C", 1'b1);
    send_text(" CARRI");
    send_item(mlmt_pkg::CHAR_NL, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 25 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 25 : 0;
      for (int half = 0; half < 2; half++) begin
        reg_write(ADDR_RING_EN, (half == 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
        bytes_sent = 0;
        while (bytes_sent < ((ph == 2) ? 100 : 150)) send_chunk();
        wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mlmt_pkg.sv
sv/mlmt_engine.sv
sv/modem_link_mode_tracker.sv
sv/mlmt_checker.sv
dv/mode_tracker_check.sv
dv/tb.sv
